/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the RTL of the route table lookup.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is disabled while the synchronous active-low reset is held.
`define IPRT_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define IPRT_ASSERT(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* hw/rtl/iprt_pkg.sv */
// ----------------------------------------------------------------------------
// iprt_pkg
// Types, constants and helper functions of the IPv4 route table lookup.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iprt_pkg;

    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ADDR_W      = 32;
    localparam int FLAGS_W     = 16;
    localparam int PLEN_W      = 6;
    localparam int OUT_IDX_W   = 6;
    localparam int REJECT_BIT  = 9;

    localparam int S_TDATA_W   = 112;
    localparam int M_TDATA_W   = 64;
    localparam int S_TUSER_W   = 2;
    localparam int M_TUSER_W   = 3;

    typedef enum logic [S_TUSER_W-1:0] {
        ACT_CLEAR  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_LOOKUP = 2'd2
    } t_action;

    typedef enum logic [M_TUSER_W-1:0] {
        ST_NONE     = 3'd0,
        ST_FOUND    = 3'd1,
        ST_UNREACH  = 3'd2,
        ST_INSERTED = 3'd3,
        ST_FULL     = 3'd4,
        ST_CLEARED  = 3'd5
    } t_status;

    typedef struct packed {
        logic [ADDR_W-1:0]  network;
        logic [ADDR_W-1:0]  mask;
        logic [PLEN_W-1:0]  plen;
        logic [ADDR_W-1:0]  gateway;
        logic [FLAGS_W-1:0] flags;
    } t_entry;

    // Prefix length is 32 minus the trailing zero count, or 0 for an empty mask.
    // The trailing zeros are found by a five-step binary search.
    function automatic logic [PLEN_W-1:0] prefix_len(input logic [ADDR_W-1:0] mask);
        logic [ADDR_W-1:0] m;
        logic [PLEN_W-1:0] tz;
        m  = mask;
        tz = '0;
        if (m[15:0] == 16'd0) begin
            tz = tz + PLEN_W'(16);
            m  = m >> 16;
        end
        if (m[7:0] == 8'd0) begin
            tz = tz + PLEN_W'(8);
            m  = m >> 8;
        end
        if (m[3:0] == 4'd0) begin
            tz = tz + PLEN_W'(4);
            m  = m >> 4;
        end
        if (m[1:0] == 2'd0) begin
            tz = tz + PLEN_W'(2);
            m  = m >> 2;
        end
        if (m[0] == 1'b0) begin
            tz = tz + PLEN_W'(1);
        end
        if (mask == '0) begin
            prefix_len = '0;
        end else begin
            prefix_len = PLEN_W'(ADDR_W) - tz;
        end
    endfunction

endpackage

/* hw/rtl/ipv4_route_table_lookup.sv */
// ----------------------------------------------------------------------------
// ipv4_route_table_lookup
// IPv4 route table with clear, insert and longest-prefix-match lookup.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Content
//   s_axis    in         tuser: action; tdata: network, mask, gateway, flags
//   m_axis    out        tuser: status; tdata: slot, gateway, prefix, flags
//
// Clear, insert, an unused action and a lookup of an empty table are answered
// from the idle state; any other lookup scans the stored routes in slot order
// and then passes S_DRAIN and S_EMIT. The scan time is set by the single read
// port of the route memory, which delivers one route a cycle. Reset clears the
// fill count and control state but not the memory; there is no clearing pass.
// A result waiting in the output register stalls the next transfer on s_axis.
//
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ipv4_route_table_lookup (
    input  logic                             i_clk,
    input  logic                             i_rst_n,

    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [31:0] net_address, [63:32] net_mask, [95:64] gateway_address,
    // [111:96] flag_word
    input  logic [iprt_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // [1:0] action
    input  logic [iprt_pkg::S_TUSER_W-1:0]   s_axis_tuser,

    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [5:0] entry_index, [37:6] found_gateway, [43:38] found_prefix_length,
    // [59:44] found_flags, [63:60] zero
    output logic [iprt_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    // [2:0] status
    output logic [iprt_pkg::M_TUSER_W-1:0]   m_axis_tuser
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } t_state;

    // The route memory. Slots fill in insertion order, so a slot is valid
    // exactly when it lies below the fill count.
    iprt_pkg::t_entry r_mem [iprt_pkg::TABLE_DEPTH];
    iprt_pkg::t_entry r_rd_data;

    t_state                          r_state, n_state;
    logic [iprt_pkg::CNT_W-1:0]      r_count, n_count;
    logic [iprt_pkg::IDX_W-1:0]      r_rd_idx, n_rd_idx;
    logic                            r_rd_vld, n_rd_vld;
    logic [iprt_pkg::IDX_W-1:0]      r_rd_slot;
    logic [iprt_pkg::ADDR_W-1:0]     r_addr;

    // Best match found so far during a lookup.
    logic                            r_have, n_have;
    logic [iprt_pkg::IDX_W-1:0]      r_best_idx;
    logic [iprt_pkg::PLEN_W-1:0]     r_best_plen;
    logic [iprt_pkg::ADDR_W-1:0]     r_best_gw;
    logic [iprt_pkg::FLAGS_W-1:0]    r_best_flags;

    // Output register.
    logic                            r_m_valid;
    iprt_pkg::t_status               r_m_status, n_m_status;
    logic [iprt_pkg::OUT_IDX_W-1:0]  r_m_idx, n_m_idx;
    logic [iprt_pkg::ADDR_W-1:0]     r_m_gw, n_m_gw;
    logic [iprt_pkg::PLEN_W-1:0]     r_m_plen, n_m_plen;
    logic [iprt_pkg::FLAGS_W-1:0]    r_m_flags, n_m_flags;

    logic                            w_out_free;
    logic                            w_accept;
    logic                            w_emit;
    logic                            w_we;
    logic                            w_take;
    logic                            w_match;
    logic                            w_last;
    logic                            w_full;

    iprt_pkg::t_action               w_action;
    iprt_pkg::t_entry                w_new;

    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && w_out_free;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_action      = iprt_pkg::t_action'(s_axis_tuser);
    assign w_full        = (r_count == iprt_pkg::CNT_W'(iprt_pkg::TABLE_DEPTH));

    assign w_new.network = s_axis_tdata[31:0];
    assign w_new.mask    = s_axis_tdata[63:32];
    assign w_new.plen    = iprt_pkg::prefix_len(s_axis_tdata[63:32]);
    assign w_new.gateway = s_axis_tdata[95:64];
    assign w_new.flags   = s_axis_tdata[111:96];

    assign w_we = w_accept && (w_action == iprt_pkg::ACT_INSERT) && !w_full;

    // The last slot to read is the one just below the fill count.
    assign w_last = (iprt_pkg::CNT_W'(r_rd_idx) + iprt_pkg::CNT_W'(1)) == r_count;

    // A longer prefix wins; at equal length a reject route displaces a
    // normal one; otherwise the earlier slot stays.
    assign w_match = ((r_rd_data.network ^ r_addr) & r_rd_data.mask) == '0;
    assign w_take  = r_rd_vld && w_match &&
                     (!r_have ||
                      (r_rd_data.plen > r_best_plen) ||
                      ((r_rd_data.plen == r_best_plen) &&
                       r_rd_data.flags[iprt_pkg::REJECT_BIT] &&
                       !r_best_flags[iprt_pkg::REJECT_BIT]));

    // Memory: one write port for inserts, one registered read port for scans.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_count[iprt_pkg::IDX_W-1:0]] <= w_new;
        end
        r_rd_data <= r_mem[r_rd_idx];
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_rd_idx   = r_rd_idx;
        n_rd_vld   = 1'b0;
        n_have     = r_have || w_take;
        w_emit     = 1'b0;
        n_m_status = iprt_pkg::ST_NONE;
        n_m_idx    = '0;
        n_m_gw     = '0;
        n_m_plen   = '0;
        n_m_flags  = '0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_action)
                        iprt_pkg::ACT_CLEAR: begin
                            n_count    = '0;
                            w_emit     = 1'b1;
                            n_m_status = iprt_pkg::ST_CLEARED;
                        end
                        iprt_pkg::ACT_INSERT: begin
                            w_emit = 1'b1;
                            if (w_full) begin
                                n_m_status = iprt_pkg::ST_FULL;
                            end else begin
                                n_count    = r_count + iprt_pkg::CNT_W'(1);
                                n_m_status = iprt_pkg::ST_INSERTED;
                                n_m_idx    = iprt_pkg::OUT_IDX_W'(r_count);
                                n_m_plen   = w_new.plen;
                            end
                        end
                        iprt_pkg::ACT_LOOKUP: begin
                            n_have = 1'b0;
                            if (r_count == '0) begin
                                w_emit = 1'b1;
                            end else begin
                                n_rd_idx = '0;
                                n_state  = S_SCAN;
                            end
                        end
                        default: begin
                            w_emit = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // The read address held now is captured by the memory this
                // cycle; its data is compared in the next one.
                n_rd_vld = 1'b1;
                if (w_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_rd_idx = r_rd_idx + iprt_pkg::IDX_W'(1);
                end
            end
            S_DRAIN: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                    if (r_have) begin
                        n_m_status = r_best_flags[iprt_pkg::REJECT_BIT] ?
                                     iprt_pkg::ST_UNREACH : iprt_pkg::ST_FOUND;
                        n_m_idx    = iprt_pkg::OUT_IDX_W'(r_best_idx);
                        n_m_gw     = r_best_gw;
                        n_m_plen   = r_best_plen;
                        n_m_flags  = r_best_flags;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_rd_idx  <= '0;
            r_rd_vld  <= 1'b0;
            r_have    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_rd_idx <= n_rd_idx;
            r_rd_vld <= n_rd_vld;
            r_have   <= n_have;
            if (w_emit) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_slot <= r_rd_idx;
        if (w_accept) begin
            r_addr <= s_axis_tdata[31:0];
        end
        if (w_take) begin
            r_best_idx   <= r_rd_slot;
            r_best_plen  <= r_rd_data.plen;
            r_best_gw    <= r_rd_data.gateway;
            r_best_flags <= r_rd_data.flags;
        end
        if (w_emit) begin
            r_m_status <= n_m_status;
            r_m_idx    <= n_m_idx;
            r_m_gw     <= n_m_gw;
            r_m_plen   <= n_m_plen;
            r_m_flags  <= n_m_flags;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tuser  = r_m_status;
    assign m_axis_tdata  = {4'd0, r_m_flags, r_m_plen, r_m_gw, r_m_idx};

    // ------------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------------
    `IPRT_ASSERT_RST(a_count_bound, i_clk, i_rst_n,
        r_count <= iprt_pkg::CNT_W'(iprt_pkg::TABLE_DEPTH),
        "fill count exceeds table depth")

    `IPRT_ASSERT_RST(a_scan_in_range, i_clk, i_rst_n,
        (r_state == S_SCAN) |-> (iprt_pkg::CNT_W'(r_rd_idx) < r_count),
        "scan reads a slot beyond the fill count")

    `IPRT_ASSERT_RST(a_insert_grows, i_clk, i_rst_n,
        (w_accept && (w_action == iprt_pkg::ACT_INSERT) && !w_full) |=>
            (r_count == $past(r_count) + iprt_pkg::CNT_W'(1)),
        "insert with room did not advance the fill count")

    `IPRT_ASSERT(a_ready_idle, i_clk,
        s_axis_tready |-> (r_state == S_IDLE),
        "input ready outside the idle state")

endmodule
